/* src/button_debounce_press_hold_defines.svh */
// ============================================================================
// Assertion macros for the button debouncer
// Shared concurrent assertion forms. Each one samples on the rising edge of
// clk and is switched off while rst_n is low.
// ============================================================================
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDPH_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDPH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bdph_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Button debouncer package
// Field widths, bus layout, operation codes, register indexes and the
// request that the top level hands to each button lane.
// ============================================================================
package bdph_pkg;

    // Default number of button lanes.
    localparam int NUM_BUTTONS_DEF = 3;

    // Fixed field widths.
    localparam int OP_W       = 3;
    localparam int BUTTON_W   = 2;
    localparam int PIN_W      = 3;
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int SCAN_W     = 8;
    localparam int MASK_W     = 3;

    // Input bus layout, lowest bit first.
    localparam int OP_LSB     = 0;
    localparam int BUTTON_LSB = OP_LSB + OP_W;
    localparam int PIN_LSB    = BUTTON_LSB + BUTTON_W;
    localparam int NOW_LSB    = PIN_LSB + PIN_W;
    localparam int HOLD_LSB   = NOW_LSB + TIME_W;
    localparam int S_FIELDS_W = HOLD_LSB + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Output bus layout, lowest bit first.
    localparam int ANSWER_LSB = 0;
    localparam int MASK_LSB   = ANSWER_LSB + 1;
    localparam int M_FIELDS_W = MASK_LSB + MASK_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = DEBOUNCE_W;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_INTERVAL = 1'b1;

    // Register reset values.
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [SCAN_W-1:0]     SCAN_RESET     = 8'd5;

    // Operation codes. Codes above OP_MASK behave as a plain scan.
    typedef enum logic [OP_W-1:0] {
        OP_SCAN          = 3'd0,
        OP_IS_PRESSED    = 3'd1,
        OP_CONSUME_PRESS = 3'd2,
        OP_CONSUME_HOLD  = 3'd3,
        OP_MASK          = 3'd4
    } op_t;

    // Per-transaction request broadcast to every lane.
    typedef struct packed {
        logic accept;    // a transaction is taken this cycle
        logic scan_en;   // the rate limiter lets this transaction scan
        logic selected;  // this lane is the queried button
        op_t  op;
    } lane_req_t;

endpackage

/* src/bdph_lane.sv */
`timescale 1ns / 1ps
// ============================================================================
// Button lane
// Debounce, press edge and hold detection for a single button. One copy
// runs per button; all copies see the same transaction in the same cycle.
// ============================================================================
module bdph_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bdph_pkg::lane_req_t        req,
    input  logic                       pin_pressed,
    input  logic [bdph_pkg::TIME_W-1:0]     now,
    input  logic [bdph_pkg::TIME_W-1:0]     hold_ms,
    input  logic [bdph_pkg::DEBOUNCE_W-1:0] settle_ms,
    output logic                       stable_pressed,
    output logic                       answer
);
    import bdph_pkg::*;

    logic              raw_reg, raw_next;
    logic              stable_reg, stable_next;
    logic              pedge_reg, pedge_next;
    logic              armed_reg, armed_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;

    logic              raw_change;
    logic              settled;
    logic              new_press;
    logic              held_long;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;

    // Elapsed times against the stored stamps. A stamp refreshed in this
    // cycle means zero elapsed time, handled by the selects below.
    assign since_change = now - change_time_reg;
    assign since_press  = now - press_time_reg;

    // Scan step, then the query against the post-scan state.
    always_comb
    begin
        raw_next         = raw_reg;
        stable_next      = stable_reg;
        pedge_next       = pedge_reg;
        armed_next       = armed_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        raw_change       = 1'b0;
        settled          = 1'b0;
        new_press        = 1'b0;
        held_long        = 1'b0;
        answer           = 1'b0;

        if (req.scan_en)
        begin
            raw_change = (pin_pressed != raw_reg);
            if (raw_change)
            begin
                raw_next         = pin_pressed;
                change_time_next = now;
                settled          = (settle_ms == '0);
            end
            else
            begin
                settled = (since_change >= {{(TIME_W-DEBOUNCE_W){1'b0}}, settle_ms});
            end

            if (settled)
            begin
                if (pin_pressed != stable_reg)
                begin
                    stable_next = pin_pressed;
                    if (pin_pressed)
                    begin
                        new_press       = 1'b1;
                        pedge_next      = 1'b1;
                        press_time_next = now;
                        armed_next      = 1'b1;
                    end
                    else
                    begin
                        pedge_next = 1'b0;
                    end
                end
            end
            else
            begin
                pedge_next = 1'b0;
            end
        end

        // A press stamped in this cycle has zero elapsed time.
        held_long = new_press ? (hold_ms == '0) : (since_press >= hold_ms);

        if (req.selected)
        begin
            case (req.op)
                OP_IS_PRESSED:
                begin
                    answer = stable_next;
                end
                OP_CONSUME_PRESS:
                begin
                    answer     = pedge_next;
                    pedge_next = 1'b0;
                end
                OP_CONSUME_HOLD:
                begin
                    if (stable_next && armed_next && held_long)
                    begin
                        answer     = 1'b1;
                        armed_next = 1'b0;
                    end
                end
                default:
                begin
                    answer = 1'b0;
                end
            endcase
        end
    end

    // Lane state, updated only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg         <= 1'b0;
            stable_reg      <= 1'b0;
            pedge_reg       <= 1'b0;
            armed_reg       <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end
        else if (req.accept)
        begin
            raw_reg         <= raw_next;
            stable_reg      <= stable_next;
            pedge_reg       <= pedge_next;
            armed_reg       <= armed_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    assign stable_pressed = stable_next;

endmodule

/* src/bdph_merge.sv */
`timescale 1ns / 1ps
// ============================================================================
// Result merge and output buffer
// Combines the lane answers and levels into one result and holds it in a
// two-slot output buffer, so input keeps flowing while a result waits.
// ============================================================================
module bdph_merge #(
    parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [NUM_BUTTONS-1:0]           lane_answer,
    input  logic [NUM_BUTTONS-1:0]           lane_stable,
    output logic                             in_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdph_pkg::M_TDATA_W-1:0]   m_tdata
);
    import bdph_pkg::*;

    logic [M_TDATA_W-1:0] result;
    logic [MASK_W-1:0]    mask;
    logic                 any_answer;
    logic                 pop;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 skid_valid_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;

    // Only the queried lane can answer, so an OR picks it out.
    assign any_answer = |lane_answer;

    // Mask covers the first MASK_W buttons that exist.
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (i < NUM_BUTTONS)
            begin
                mask[i] = lane_stable[i];
            end
        end
    end

    always_comb
    begin
        result                              = '0;
        result[ANSWER_LSB]                  = any_answer;
        result[MASK_LSB +: MASK_W]          = mask;
    end

    assign pop      = out_valid_reg && m_tready;
    assign in_ready = !skid_valid_reg;

    // Two-slot buffer: the skid slot catches a transaction taken while the
    // output slot is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* src/button_debounce_press_hold.sv */
`timescale 1ns / 1ps
// ============================================================================
// Button debouncer with press and hold detection
// Timestamp driven debounce of active-low buttons, with one lane per button,
// a rate-limited scan, press edge and once-per-press hold events.
// ============================================================================
//
//  Channel  Direction  Contents (lowest bit first)
//  -------  ---------  ------------------------------------------------------
//  s_*      in         operation, button, pin_levels, time_ms, hold_ms
//  m_*      out        answer, pressed_mask
//  cfg_*    in         index 0 debounce time, index 1 scan interval
//
//  One transaction is taken per cycle while s_tready is high; its result is
//  registered into the output buffer. All lanes update in the same cycle from
//  registered state, with two 32-bit subtracts and compares per lane.
//  s_tready drops only when both output buffer slots hold results.
//  Reset returns every button to released and the registers to 20 and 5.
//
module button_debounce_press_hold #(
    parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // operation[2:0], button[4:3], pin_levels[7:5], time_ms[39:8],
    // hold_ms[71:40]
    input  logic [bdph_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // answer[0], pressed_mask[3:1], zeros above
    output logic [bdph_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [bdph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bdph_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bdph_pkg::*;

    localparam int MappedButtons = (NUM_BUTTONS < PIN_W) ? NUM_BUTTONS : PIN_W;

    logic [OP_W-1:0]       operation;
    logic [BUTTON_W-1:0]   button;
    logic [PIN_W-1:0]      pin_levels;
    logic [TIME_W-1:0]     time_ms;
    logic [TIME_W-1:0]     hold_ms;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [SCAN_W-1:0]     scan_interval_reg;
    logic [TIME_W-1:0]     last_scan_reg;

    logic                  push;
    logic                  scan_en;
    logic                  mapped;
    logic [TIME_W-1:0]     since_scan;
    logic [NUM_BUTTONS-1:0] lane_answer;
    logic [NUM_BUTTONS-1:0] lane_stable;

    // Unpack the input transaction.
    assign operation  = s_tdata[OP_LSB +: OP_W];
    assign button     = s_tdata[BUTTON_LSB +: BUTTON_W];
    assign pin_levels = s_tdata[PIN_LSB +: PIN_W];
    assign time_ms    = s_tdata[NOW_LSB +: TIME_W];
    assign hold_ms    = s_tdata[HOLD_LSB +: TIME_W];

    assign push   = s_tvalid && s_tready;
    assign mapped = (int'(button) < MappedButtons);

    // Rate limiter for the debounce scan.
    assign since_scan = time_ms - last_scan_reg;
    assign scan_en    = (since_scan >= {{(TIME_W-SCAN_W){1'b0}}, scan_interval_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_scan_reg <= '0;
        end
        else if (push && scan_en)
        begin
            last_scan_reg <= time_ms;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RESET;
            scan_interval_reg <= SCAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:      debounce_reg      <= cfg_data;
                REG_SCAN_INTERVAL: scan_interval_reg <= cfg_data[SCAN_W-1:0];
                default:           debounce_reg      <= debounce_reg;
            endcase
        end
    end

    // One lane per button. Buttons without a pin read as pressed.
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        lane_req_t req;
        logic      pin_pressed;

        assign req.accept   = push;
        assign req.scan_en  = scan_en;
        assign req.selected = mapped && (int'(button) == i);
        assign req.op       = op_t'(operation);

        if (i < PIN_W)
        begin : g_pin
            assign pin_pressed = !pin_levels[i];
        end
        else
        begin : g_nopin
            assign pin_pressed = 1'b1;
        end

        bdph_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .req            (req),
            .pin_pressed    (pin_pressed),
            .now            (time_ms),
            .hold_ms        (hold_ms),
            .settle_ms      (debounce_reg),
            .stable_pressed (lane_stable[i]),
            .answer         (lane_answer[i])
        );
    end

    // Merge lane results and buffer the output transaction.
    bdph_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .lane_answer (lane_answer),
        .lane_stable (lane_stable),
        .in_ready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* src/bdph_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Port checker for the button debouncer
// Watches the top-level ports for buffering and result formatting slips.
// ============================================================================
`include "button_debounce_press_hold_defines.svh"

module bdph_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bdph_pkg::M_TDATA_W-1:0] m_tdata
);
    import bdph_pkg::*;

    // Back-pressure on the input only comes from a full, stalled output.
    `BDPH_ASSERT_SAME(a_ready_only_when_full, !s_tready, m_tvalid, "input stalled while output empty")

    // The output is valid in the cycle after every accepted transaction.
    `BDPH_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "accepted transaction lost")

    // Stalled results stay in place.
    `BDPH_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Bits above the result fields are always zero.
    `BDPH_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0, "nonzero padding in result")

endmodule

bind button_debounce_press_hold bdph_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
